// ===== src/skf_pkg.sv =====
// shared types and constants for the scalar kalman filter
// sequencer state codes, control and status bundles, register indexes, reset values
`default_nettype none

package skf_pkg;

	// gain is unsigned q0.32, one quotient or multiplier bit per loop step
	localparam int GAIN_BITS = 32;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE = 2'd2;

	// register reset values, q10.38, cut to the variance width where used
	localparam logic [63:0] PROCESS_NOISE_RST    = 64'd2748779;
	localparam logic [63:0] MEASURE_NOISE_RST    = 64'd27487791;
	localparam logic [63:0] INITIAL_VARIANCE_RST = 64'd137438953472000;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_PRED = 13'b0000000000010,
		S_DEN  = 13'b0000000000100,
		S_DIV  = 13'b0000000001000,
		S_DIFF = 13'b0000000010000,
		S_ABS  = 13'b0000000100000,
		S_MULX = 13'b0000001000000,
		S_RNDX = 13'b0000010000000,
		S_UPDX = 13'b0000100000000,
		S_MULP = 13'b0001000000000,
		S_RNDP = 13'b0010000000000,
		S_UPDP = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	typedef struct packed {
		state_t           st;
		logic [CNT_W-1:0] cnt;
		logic             accept;
		logic             out_load;
	} ctrl_t;

	typedef struct packed {
		logic started;
		logic den_ovf;
		logic rn_zero;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/scalar_kalman_filter.sv =====
// scalar kalman filter (a = h = 1), top level; uses skf_pkg, skf_ctrl, skf_dp, skf_alu
// first sample after reset: passed through, the sequencer going from idle straight to the final step
// later samples: three 32-step loops on one shared adder (gain divide, estimate multiply,
//   variance multiply) plus single add steps; the divide is skipped when r is zero
// one item in flight; next beat accepted once the result sits in the output register
// async active-low reset: filter unstarted, estimate and variance zero, registers at defaults
`default_nettype none

module scalar_kalman_filter #(
	parameter int SAMPLE_WIDTH   = 32,
	parameter int VARIANCE_WIDTH = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// measurement channel
	input  wire logic                              meas_valid,
	output logic                                   meas_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    measurement,
	// estimate channel
	output logic                                   est_valid,
	input  wire logic                              est_stall,
	output logic signed [SAMPLE_WIDTH-1:0]         estimate,
	// config write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [VARIANCE_WIDTH-1:0]         cfg_data
);

	skf_pkg::ctrl_t                ctrl;
	skf_pkg::stat_t                stat;
	logic signed [SAMPLE_WIDTH-1:0] x_value;
	logic                          est_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] estimate_q;

	// the user must write config only while idle (not enforced here), so every write beat is taken at once
	assign cfg_ready = 1'b1;

	// a new measurement beat is taken only while the sequencer sits idle
	assign meas_stall = (ctrl.st != skf_pkg::S_IDLE);

	// sequencer: walks predict, gain divide, estimate and variance updates
	skf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.est_valid  (est_valid_q),
		.est_stall  (est_stall),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	// datapath: registers plus the one shared adder
	skf_dp #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.VARIANCE_WIDTH (VARIANCE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.measurement (measurement),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.x_value     (x_value)
	);

	// output register: holds the result beat until the consumer takes it,
	// so the sequencer can go back to idle and take the next measurement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			est_valid_q <= 1'b1;
		end else if (!est_stall) begin
			est_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			estimate_q <= x_value;
		end
	end

	assign est_valid = est_valid_q;
	assign estimate  = estimate_q;

	// an accepted beat always starts work, so the next cycle stalls the channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(meas_valid && !meas_stall) |=> meas_stall)
		else $error("measurement channel open right after an accepted beat");

	// a result beat appears only out of the final sequencer step
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(est_valid) |-> $past(ctrl.st == skf_pkg::S_DONE))
		else $error("result beat raised outside the final step");

	// the gain divide runs exactly 32 steps and then moves on
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		((ctrl.st == skf_pkg::S_DIV) && (&ctrl.cnt)) |=> (ctrl.st == skf_pkg::S_DIFF))
		else $error("gain divide did not end after its last step");

endmodule

`default_nettype wire

// ===== src/skf_alu.sv =====
// shared add/subtract unit of the scalar kalman filter
// no package dependency; carry out doubles as the no-borrow flag
`default_nettype none

module skf_alu #(
	parameter int W = 80
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W:0]   sum
);

	assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};

endmodule

`default_nettype wire

// ===== src/skf_ctrl.sv =====
// sequencer of the scalar kalman filter
// uses skf_pkg for state codes and the control/status bundles
`default_nettype none

module skf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           meas_valid,
	input  wire logic           est_valid,
	input  wire logic           est_stall,
	input  wire skf_pkg::stat_t stat,
	output skf_pkg::ctrl_t      ctrl
);

	skf_pkg::state_t                 state_q;
	skf_pkg::state_t                 state_nxt;
	logic [skf_pkg::CNT_W-1:0]       cnt_q;
	logic                            looping;
	logic                            last;
	logic                            out_load;

	assign looping  = (state_q == skf_pkg::S_DIV) || (state_q == skf_pkg::S_MULX) ||
		(state_q == skf_pkg::S_MULP);
	assign last     = &cnt_q;
	assign out_load = (state_q == skf_pkg::S_DONE) && (!est_valid || !est_stall);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			skf_pkg::S_IDLE: begin
				if (meas_valid) begin
					state_nxt = stat.started ? skf_pkg::S_PRED : skf_pkg::S_DONE;
				end
			end
			skf_pkg::S_PRED: state_nxt = skf_pkg::S_DEN;
			skf_pkg::S_DEN: begin
				if (!stat.den_ovf) begin
					state_nxt = stat.rn_zero ? skf_pkg::S_DIFF : skf_pkg::S_DIV;
				end
			end
			skf_pkg::S_DIV: begin
				if (last) begin
					state_nxt = skf_pkg::S_DIFF;
				end
			end
			skf_pkg::S_DIFF: state_nxt = skf_pkg::S_ABS;
			skf_pkg::S_ABS:  state_nxt = skf_pkg::S_MULX;
			skf_pkg::S_MULX: begin
				if (last) begin
					state_nxt = skf_pkg::S_RNDX;
				end
			end
			skf_pkg::S_RNDX: state_nxt = skf_pkg::S_UPDX;
			skf_pkg::S_UPDX: state_nxt = skf_pkg::S_MULP;
			skf_pkg::S_MULP: begin
				if (last) begin
					state_nxt = skf_pkg::S_RNDP;
				end
			end
			skf_pkg::S_RNDP: state_nxt = skf_pkg::S_UPDP;
			skf_pkg::S_UPDP: state_nxt = skf_pkg::S_DONE;
			skf_pkg::S_DONE: begin
				if (out_load) begin
					state_nxt = skf_pkg::S_IDLE;
				end
			end
			default: state_nxt = skf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= looping ? cnt_q + 1'b1 : '0;
		end
	end

	assign ctrl.st       = state_q;
	assign ctrl.cnt      = cnt_q;
	assign ctrl.accept   = (state_q == skf_pkg::S_IDLE) && meas_valid;
	assign ctrl.out_load = out_load;

endmodule

`default_nettype wire

// ===== src/skf_dp.sv =====
// datapath of the scalar kalman filter: config registers, filter state, work registers
// uses skf_pkg and one skf_alu shared by every step
`default_nettype none

module skf_dp #(
	parameter int SAMPLE_WIDTH   = 32,
	parameter int VARIANCE_WIDTH = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire skf_pkg::ctrl_t                    ctrl,
	output skf_pkg::stat_t                         stat,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    measurement,
	input  wire logic                              cfg_wr,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [VARIANCE_WIDTH-1:0]         cfg_data,
	output logic signed [SAMPLE_WIDTH-1:0]         x_value
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int VW = VARIANCE_WIDTH;
	localparam int GB = skf_pkg::GAIN_BITS;
	localparam int RW = VW + 1;
	localparam int AW = (VW + GB > SW + GB + 1) ? VW + GB : SW + GB + 1;
	// the sum p'+r is halved on a carry out of the variance width only when that width is 64 or more
	localparam bit HALVE = (VW >= 64);

	logic [VW-1:0]        q_q, r_q, init_q;
	logic                 started_q;
	logic signed [SW-1:0] x_q, z_q;
	logic [VW-1:0]        p_q, pp_q, num_q, rn_q;
	logic [RW-1:0]        den_q, rem_q;
	logic [GB-1:0]        gain_q;
	logic signed [SW:0]   diff_q;
	logic [SW:0]          mag_q;
	logic                 neg_q;
	logic [AW-1:0]        acc_q;

	logic [AW-1:0]        op_a, op_b;
	logic                 op_sub;
	logic [AW:0]          sum;
	logic [AW-SW:0]       upper;
	logic                 x_ovf;
	logic                 gain_bit;

	skf_alu #(.W(AW)) u_alu (
		.a   (op_a),
		.b   (op_b),
		.sub (op_sub),
		.sum (sum)
	);

	assign gain_bit = gain_q[~ctrl.cnt];

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (ctrl.st)
			skf_pkg::S_PRED: begin
				op_a = AW'(p_q);
				op_b = AW'(q_q);
			end
			skf_pkg::S_DEN: begin
				op_a = AW'(num_q);
				op_b = AW'(rn_q);
			end
			skf_pkg::S_DIV: begin
				op_a   = AW'({rem_q, 1'b0});
				op_b   = AW'(den_q);
				op_sub = 1'b1;
			end
			skf_pkg::S_DIFF: begin
				op_a   = AW'(z_q);
				op_b   = AW'(x_q);
				op_sub = 1'b1;
			end
			skf_pkg::S_ABS: begin
				op_b   = AW'(diff_q);
				op_sub = diff_q[SW];
			end
			skf_pkg::S_MULX: begin
				op_a = {acc_q[AW-2:0], 1'b0};
				op_b = gain_bit ? AW'(mag_q) : '0;
			end
			skf_pkg::S_RNDX: begin
				op_a = acc_q;
				op_b = AW'(1) << (GB - 1);
			end
			skf_pkg::S_UPDX: begin
				op_a   = AW'(x_q);
				op_b   = AW'(acc_q[AW-1:GB]);
				op_sub = neg_q;
			end
			skf_pkg::S_MULP: begin
				op_a = {acc_q[AW-2:0], 1'b0};
				op_b = gain_bit ? AW'(pp_q) : '0;
			end
			skf_pkg::S_RNDP: begin
				op_a = acc_q;
				op_b = AW'({GB{1'b1}});
			end
			skf_pkg::S_UPDP: begin
				op_a   = AW'(pp_q);
				op_b   = AW'(acc_q[AW-1:GB]);
				op_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// signed result leaves the sample range when the sign bit and the bits above it disagree
	assign upper = sum[AW-1:SW-1];
	assign x_ovf = !((&upper) || (~|upper));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= skf_pkg::PROCESS_NOISE_RST[VW-1:0];
			r_q    <= skf_pkg::MEASURE_NOISE_RST[VW-1:0];
			init_q <= skf_pkg::INITIAL_VARIANCE_RST[VW-1:0];
		end else if (cfg_wr) begin
			case (cfg_index)
				skf_pkg::REG_PROCESS_NOISE:    q_q    <= cfg_data;
				skf_pkg::REG_MEASURE_NOISE:    r_q    <= cfg_data;
				skf_pkg::REG_INITIAL_VARIANCE: init_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			x_q       <= '0;
			p_q       <= '0;
		end else begin
			if (ctrl.accept && !started_q) begin
				started_q <= 1'b1;
				x_q       <= measurement;
				p_q       <= init_q;
			end
			if (ctrl.st == skf_pkg::S_UPDX) begin
				if (x_ovf) begin
					x_q <= sum[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
				end else begin
					x_q <= sum[SW-1:0];
				end
			end
			if (ctrl.st == skf_pkg::S_UPDP) begin
				p_q <= sum[VW-1:0];
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			z_q <= measurement;
		end
		case (ctrl.st)
			skf_pkg::S_PRED: begin
				pp_q  <= sum[VW] ? '1 : sum[VW-1:0];
				num_q <= sum[VW] ? '1 : sum[VW-1:0];
				rn_q  <= r_q;
			end
			skf_pkg::S_DEN: begin
				if (HALVE && sum[VW]) begin
					num_q <= num_q >> 1;
					rn_q  <= rn_q >> 1;
				end else begin
					den_q  <= sum[RW-1:0];
					rem_q  <= RW'(num_q);
					gain_q <= '0;
					if (rn_q == '0) begin
						gain_q <= (num_q == '0) ? '0 : '1;
					end
				end
			end
			skf_pkg::S_DIV: begin
				if (sum[AW]) begin
					rem_q <= sum[RW-1:0];
				end else begin
					rem_q <= {rem_q[RW-2:0], 1'b0};
				end
				gain_q <= {gain_q[GB-2:0], sum[AW]};
			end
			skf_pkg::S_DIFF: diff_q <= sum[SW:0];
			skf_pkg::S_ABS: begin
				mag_q <= sum[SW:0];
				neg_q <= diff_q[SW];
				acc_q <= '0;
			end
			skf_pkg::S_MULX, skf_pkg::S_RNDX, skf_pkg::S_MULP, skf_pkg::S_RNDP: begin
				acc_q <= sum[AW-1:0];
			end
			skf_pkg::S_UPDX: acc_q <= '0;
			default: begin
			end
		endcase
	end

	assign stat.started = started_q;
	assign stat.den_ovf = HALVE && sum[VW];
	assign stat.rn_zero = (rn_q == '0);
	assign x_value      = x_q;

endmodule

`default_nettype wire
